[rtl/iir_df_pkg.sv]
package iir_df_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COEF_BITS_DEF   = 16;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_FF_COEF_0 = 2'd0,
        REG_FF_COEF_1 = 2'd1,
        REG_FB_COEF_1 = 2'd2,
        REG_FB_COEF_2 = 2'd3
    } reg_idx_t;

endpackage

[rtl/iir_df_regs.sv]
module iir_df_regs
    import iir_df_pkg::*;
#(
    parameter int COEF_BITS = COEF_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready,
    output logic signed [COEF_BITS-1:0]  ff_coef_0,
    output logic signed [COEF_BITS-1:0]  ff_coef_1,
    output logic signed [COEF_BITS-1:0]  fb_coef_1,
    output logic signed [COEF_BITS-1:0]  fb_coef_2
);

    logic signed [COEF_BITS-1:0] ff0_reg;
    logic signed [COEF_BITS-1:0] ff1_reg;
    logic signed [COEF_BITS-1:0] fb1_reg;
    logic signed [COEF_BITS-1:0] fb2_reg;
    logic signed [COEF_BITS-1:0] wr_coef;
    reg_idx_t                    reg_idx;
    logic                        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign wr_coef = $signed(pwdata[COEF_BITS-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ff0_reg <= '0;
            ff1_reg <= '0;
            fb1_reg <= '0;
            fb2_reg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_FF_COEF_0: ff0_reg <= wr_coef;
                REG_FF_COEF_1: ff1_reg <= wr_coef;
                REG_FB_COEF_1: fb1_reg <= wr_coef;
                REG_FB_COEF_2: fb2_reg <= wr_coef;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FF_COEF_0: prdata = APB_DATA_W'(ff0_reg);
            REG_FF_COEF_1: prdata = APB_DATA_W'(ff1_reg);
            REG_FB_COEF_1: prdata = APB_DATA_W'(fb1_reg);
            REG_FB_COEF_2: prdata = APB_DATA_W'(fb2_reg);
            default:       prdata = '0;
        endcase
    end

    assign ff_coef_0 = ff0_reg;
    assign ff_coef_1 = ff1_reg;
    assign fb_coef_1 = fb1_reg;
    assign fb_coef_2 = fb2_reg;

endmodule

[rtl/iir_df_core.sv]
module iir_df_core
    import iir_df_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = COEF_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic signed [SAMPLE_BITS-1:0] x,
    input  logic                          start,
    input  logic signed [COEF_BITS-1:0]   ff_coef_0,
    input  logic signed [COEF_BITS-1:0]   ff_coef_1,
    input  logic signed [COEF_BITS-1:0]   fb_coef_1,
    input  logic signed [COEF_BITS-1:0]   fb_coef_2,
    output logic signed [SAMPLE_BITS-1:0] y,
    output logic                          clip
);

    localparam int P_W      = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_FULL = P_W + 3;
    localparam int ACC_W    = (ACC_FULL > 64) ? 64 : ACC_FULL;
    localparam int FRAC     = COEF_BITS - 1;
    localparam int Q_W      = ACC_W - FRAC;

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W-1:0] s;
        s = a + b;
        if ((a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1])) begin
            s = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return s;
    endfunction

    logic signed [SAMPLE_BITS-1:0] x1_reg;
    logic signed [SAMPLE_BITS-1:0] y1_reg;
    logic signed [SAMPLE_BITS-1:0] y2_reg;
    logic signed [SAMPLE_BITS-1:0] x1_next;
    logic signed [SAMPLE_BITS-1:0] y1_next;
    logic signed [SAMPLE_BITS-1:0] y2_next;
    logic signed [SAMPLE_BITS-1:0] h_x1;
    logic signed [SAMPLE_BITS-1:0] h_y1;
    logic signed [SAMPLE_BITS-1:0] h_y2;
    logic signed [P_W-1:0]         p0;
    logic signed [P_W-1:0]         p1;
    logic signed [P_W-1:0]         p2;
    logic signed [P_W-1:0]         p3;
    logic signed [ACC_W-1:0]       acc;
    logic signed [ACC_W-1:0]       shifted;
    logic signed [Q_W-1:0]         q;
    logic [Q_W-SAMPLE_BITS:0]      q_hi;
    logic                          in_range;

    assign h_x1 = start ? '0 : x1_reg;
    assign h_y1 = start ? '0 : y1_reg;
    assign h_y2 = start ? '0 : y2_reg;

    assign p0 = ff_coef_0 * x;
    assign p1 = ff_coef_1 * h_x1;
    assign p2 = fb_coef_1 * h_y1;
    assign p3 = fb_coef_2 * h_y2;

    always_comb begin
        acc = ACC_W'(p0);
        acc = sat_add(acc, ACC_W'(p1));
        acc = sat_add(acc, ACC_W'(p2));
        acc = sat_add(acc, ACC_W'(p3));
        acc = sat_add(acc, ACC_W'(1) <<< (FRAC - 1));
    end

    assign shifted  = acc >>> FRAC;
    assign q        = $signed(shifted[Q_W-1:0]);
    assign q_hi     = q[Q_W-1:SAMPLE_BITS-1];
    assign in_range = (&q_hi) || !(|q_hi);

    always_comb begin
        if (in_range) begin
            y = $signed(q[SAMPLE_BITS-1:0]);
        end else if (q[Q_W-1]) begin
            y = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            y = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    assign clip = !in_range;

    assign x1_next = step ? x    : x1_reg;
    assign y1_next = step ? y    : y1_reg;
    assign y2_next = step ? h_y1 : y2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x1_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
        end else begin
            x1_reg <= x1_next;
            y1_reg <= y1_next;
            y2_reg <= y2_next;
        end
    end

endmodule

[rtl/iir_filter_direct_form.sv]
// Direct-form-I IIR filter, y[n] = ff0*x[n] + ff1*x[n-1] + fb1*y[n-1] + fb2*y[n-2], with the
// feedback terms added. Coefficients are signed Q1.(COEF_BITS-1) registers at byte addresses
// 0, 4, 8 and 12 (ff_coef_0, ff_coef_1, fb_coef_1, fb_coef_2), all zero after reset. A beat
// with tuser set clears the input and output history before it is filtered. The four products
// are summed exactly, rounded half up, shifted right by COEF_BITS-1 and saturated to a
// SAMPLE_BITS sample; m_tuser flags a saturated result. The block takes one beat per clock
// cycle while m_tready does not stall the output: a beat is held in the input register, its
// result is computed there combinationally because the next sample needs this output as
// feedback, and it moves into the output register, which drives m_tvalid, once that register
// is empty or its result is being taken with m_tready.
module iir_filter_direct_form
    import iir_df_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = COEF_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // sample_in
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,
    // stream_start
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // sample_out
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_tdata,
    // clipped
    output logic                                  m_tuser,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [APB_ADDR_W-1:0]                 paddr,
    input  logic [APB_DATA_W-1:0]                 pwdata,
    output logic [APB_DATA_W-1:0]                 prdata,
    output logic                                  pready
);

    localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

    logic signed [COEF_BITS-1:0]   ff_coef_0;
    logic signed [COEF_BITS-1:0]   ff_coef_1;
    logic signed [COEF_BITS-1:0]   fb_coef_1;
    logic signed [COEF_BITS-1:0]   fb_coef_2;

    logic                          in_valid_reg;
    logic                          in_valid_next;
    logic signed [SAMPLE_BITS-1:0] in_x_reg;
    logic                          in_start_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_y_reg;
    logic                          out_clip_reg;
    logic signed [SAMPLE_BITS-1:0] core_y;
    logic                          core_clip;
    logic                          s_fire;
    logic                          advance;

    iir_df_regs #(
        .COEF_BITS (COEF_BITS)
    ) u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .ff_coef_0 (ff_coef_0),
        .ff_coef_1 (ff_coef_1),
        .fb_coef_1 (fb_coef_1),
        .fb_coef_2 (fb_coef_2)
    );

    iir_df_core #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .x         (in_x_reg),
        .start     (in_start_reg),
        .ff_coef_0 (ff_coef_0),
        .ff_coef_1 (ff_coef_1),
        .fb_coef_1 (fb_coef_1),
        .fb_coef_2 (fb_coef_2),
        .y         (core_y),
        .clip      (core_clip)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_comb begin
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_x_reg     <= $signed(s_tdata[SAMPLE_BITS-1:0]);
            in_start_reg <= s_tuser;
        end
        if (advance) begin
            out_y_reg    <= core_y;
            out_clip_reg <= core_clip;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DATA_W'($unsigned(out_y_reg));
    assign m_tuser  = out_clip_reg;

endmodule
